>>> rtl/core/rsrp_pkg.sv
// shared types, codes and constants for the route state record parser
`default_nettype none

package rsrp_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROUTE_LIMIT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_LIMIT         = 2'd2;

  localparam logic [15:0] EXPECTED_VERSION_RST = 16'd1;
  localparam logic [15:0] ROUTE_LIMIT_RST      = 16'd64;
  localparam logic [7:0]  ID_LIMIT_RST         = 8'd64;

  localparam logic [3:0] HEADER_BYTES = 4'd8;

  localparam logic [7:0] MAGIC_0 = 8'h56;
  localparam logic [7:0] MAGIC_1 = 8'h4D;
  localparam logic [7:0] MAGIC_2 = 8'h4F;
  localparam logic [7:0] MAGIC_3 = 8'h44;

  localparam logic [3:0] ROLE_MAGIC     = 4'd0;
  localparam logic [3:0] ROLE_VERSION   = 4'd1;
  localparam logic [3:0] ROLE_COUNT     = 4'd2;
  localparam logic [3:0] ROLE_KIND      = 4'd3;
  localparam logic [3:0] ROLE_INDEX     = 4'd4;
  localparam logic [3:0] ROLE_TRANSFORM = 4'd5;
  localparam logic [3:0] ROLE_PAD       = 4'd6;
  localparam logic [3:0] ROLE_DEPTH     = 4'd7;
  localparam logic [3:0] ROLE_LENGTHS   = 4'd8;
  localparam logic [3:0] ROLE_RESERVED  = 4'd9;
  localparam logic [3:0] ROLE_INSTR     = 4'd10;
  localparam logic [3:0] ROLE_PARAM     = 4'd11;
  localparam logic [3:0] ROLE_IGNORED   = 4'd12;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_SCHEMA  = 2'd2;
  localparam logic [1:0] ST_ROUTE   = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [15:0] route_number;
    logic [31:0] field_value;
    logic        field_done;
    logic        done_res;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] expected_version;
    logic [15:0] route_limit;
    logic [7:0]  id_limit;
  } cfg_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = MAGIC_0;
      2'd1: b = MAGIC_1;
      2'd2: b = MAGIC_2;
      default: b = MAGIC_3;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rsrp_parser.sv
// per-byte parse state and the combinational step that updates it
`default_nettype none

module rsrp_parser
  import rsrp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_en,
  input  wire in_word_t  word,
  input  wire cfg_t      cfg,
  output out_word_t      result
);

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  pos;
    logic [3:0]  total;
    logic [15:0] routes_expected;
    logic [15:0] routes_seen;
    logic [7:0]  instr_rem;
    logic [7:0]  param_rem;
    logic [31:0] acc;
    logic        dnf;
    logic [1:0]  lstat;
    logic        err;
  } pstate_t;

  localparam pstate_t PSTATE_RST = '{
    phase: ROLE_MAGIC, pos: 4'd0, total: 4'd0, routes_expected: 16'd0,
    routes_seen: 16'd0, instr_rem: 8'd0, param_rem: 8'd0, acc: 32'd0,
    dnf: 1'b0, lstat: ST_OK, err: 1'b0
  };

  pstate_t st_r;
  pstate_t st_nxt;

  function automatic pstate_t do_fail(input pstate_t s, input logic [1:0] code);
    pstate_t t;
    t = s;
    if (!t.err) begin
      t.err   = 1'b1;
      t.lstat = code;
    end
    t.phase = ROLE_IGNORED;
    return t;
  endfunction

  function automatic pstate_t route_end(input pstate_t s);
    pstate_t t;
    t = s;
    if (t.dnf) begin
      t = do_fail(t, ST_ROUTE);
    end else begin
      t.routes_seen = 16'(t.routes_seen + 16'd1);
      t.phase = (t.routes_seen >= t.routes_expected) ? ROLE_IGNORED : ROLE_KIND;
    end
    return t;
  endfunction

  function automatic pstate_t gather(input pstate_t s, input logic [31:0] acc_new,
                                     input logic [3:0] pos_inc, input logic full);
    pstate_t t;
    t = s;
    if (full) begin
      t.acc = 32'd0;
      t.pos = 4'd0;
    end else begin
      t.acc = acc_new;
      t.pos = pos_inc;
    end
    return t;
  endfunction

  logic [7:0]  b;
  logic [31:0] acc_new;
  logic [3:0]  pos_inc;
  logic        full2;
  logic        full4;
  logic [3:0]  role;
  logic [15:0] route;
  logic [31:0] val;
  logic        fd;
  logic [1:0]  stat;

  assign b       = word.byte_value;
  assign acc_new = st_r.acc | ({24'd0, b} << {st_r.pos[1:0], 3'b000});
  assign pos_inc = 4'(st_r.pos + 4'd1);
  assign full2   = pos_inc >= 4'd2;
  assign full4   = pos_inc >= 4'd4;

  always_comb begin
    st_nxt = st_r;
    role   = st_r.phase;
    route  = (st_r.phase <= ROLE_COUNT) ? 16'd0 : st_r.routes_seen;
    val    = 32'd0;
    fd     = 1'b0;
    stat   = ST_OK;

    if (st_r.total < HEADER_BYTES) st_nxt.total = 4'(st_r.total + 4'd1);

    unique case (st_r.phase) inside
      ROLE_MAGIC: begin
        if (b != magic_byte(st_r.pos[1:0])) begin
          st_nxt = do_fail(st_nxt, ST_CORRUPT);
        end else begin
          st_nxt = gather(st_nxt, acc_new, pos_inc, full4);
          if (full4) begin
            fd = 1'b1;
            val = acc_new;
            st_nxt.phase = ROLE_VERSION;
          end
        end
      end
      ROLE_VERSION: begin
        st_nxt = gather(st_nxt, acc_new, pos_inc, full2);
        if (full2) begin
          fd = 1'b1;
          val = acc_new;
          if (acc_new != {16'd0, cfg.expected_version}) st_nxt = do_fail(st_nxt, ST_SCHEMA);
          else st_nxt.phase = ROLE_COUNT;
        end
      end
      ROLE_COUNT: begin
        st_nxt = gather(st_nxt, acc_new, pos_inc, full2);
        if (full2) begin
          fd = 1'b1;
          val = acc_new;
          st_nxt.routes_expected = acc_new[15:0];
          if (acc_new[15:0] > cfg.route_limit) st_nxt = do_fail(st_nxt, ST_CORRUPT);
          else st_nxt.phase = (acc_new[15:0] == 16'd0) ? ROLE_IGNORED : ROLE_KIND;
        end
      end
      ROLE_KIND, ROLE_INDEX, ROLE_TRANSFORM: begin
        fd = 1'b1;
        val = {24'd0, b};
        st_nxt.phase = 4'(st_r.phase + 4'd1);
      end
      ROLE_PAD: begin
        fd = 1'b1;
        val = {24'd0, b};
        if (b != 8'd0) st_nxt = do_fail(st_nxt, ST_CORRUPT);
        else st_nxt.phase = ROLE_DEPTH;
      end
      ROLE_DEPTH: begin
        st_nxt = gather(st_nxt, acc_new, pos_inc, full4);
        if (full4) begin
          fd = 1'b1;
          val = acc_new;
          st_nxt.dnf = (acc_new[30:23] == 8'hFF);
          st_nxt.phase = ROLE_LENGTHS;
        end
      end
      ROLE_LENGTHS: begin
        if (st_r.pos == 4'd0) st_nxt.instr_rem = b;
        else st_nxt.param_rem = b;
        st_nxt = gather(st_nxt, acc_new, pos_inc, full2);
        if (full2) begin
          fd = 1'b1;
          val = acc_new;
          st_nxt.phase = ROLE_RESERVED;
        end
      end
      ROLE_RESERVED: begin
        st_nxt = gather(st_nxt, acc_new, pos_inc, full2);
        if (full2) begin
          fd = 1'b1;
          val = acc_new;
          if (acc_new != 32'd0 || st_r.instr_rem > cfg.id_limit ||
              st_r.param_rem > cfg.id_limit) begin
            st_nxt = do_fail(st_nxt, ST_CORRUPT);
          end else if (st_r.instr_rem != 8'd0) begin
            st_nxt.phase = ROLE_INSTR;
          end else if (st_r.param_rem != 8'd0) begin
            st_nxt.phase = ROLE_PARAM;
          end else begin
            st_nxt = route_end(st_nxt);
          end
        end
      end
      ROLE_INSTR: begin
        if (st_r.instr_rem != 8'd0) st_nxt.instr_rem = st_r.instr_rem - 8'd1;
        if (st_nxt.instr_rem == 8'd0) begin
          if (st_r.param_rem != 8'd0) st_nxt.phase = ROLE_PARAM;
          else st_nxt = route_end(st_nxt);
        end
      end
      ROLE_PARAM: begin
        if (st_r.param_rem != 8'd0) st_nxt.param_rem = st_r.param_rem - 8'd1;
        if (st_nxt.param_rem == 8'd0) st_nxt = route_end(st_nxt);
      end
      default: begin
        role = ROLE_IGNORED;
        st_nxt = do_fail(st_nxt, ST_CORRUPT);
      end
    endcase

    if (word.last_byte) begin
      if (st_nxt.total < HEADER_BYTES) stat = ST_CORRUPT;
      else if (st_nxt.err) stat = st_nxt.lstat;
      else if (st_nxt.phase != ROLE_IGNORED) stat = ST_CORRUPT;
      else stat = ST_OK;
    end

    result.byte_role    = role;
    result.route_number = route;
    result.field_value  = val;
    result.field_done   = fd;
    result.done_res     = word.last_byte;
    result.status       = stat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PSTATE_RST;
    end else if (step_en) begin
      st_r <= word.last_byte ? PSTATE_RST : st_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/route_state_record_parser.sv
// top level: input register, config registers, parser step and result register
// an accepted word is held in the input register, stepped by the parser and captured in the output register
// throughput: one word per cycle while out_ready lets the output register advance, set by the parse state update
// a result waiting in the output register does not stop an empty input register filling
// reset (rst_n low, synchronous) clears the parse state, empties both registers
// and returns the config registers to their defaults
`default_nettype none

module route_state_record_parser
  import rsrp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_word_t               in_word,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_word_t                   out_word,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t step_result;
  logic      adv;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  rsrp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_valid_r && adv),
    .word    (s1_word_r),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_version <= EXPECTED_VERSION_RST;
      cfg_r.route_limit      <= ROUTE_LIMIT_RST;
      cfg_r.id_limit         <= ID_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EXPECTED_VERSION: cfg_r.expected_version <= cfg_data;
        CFG_ROUTE_LIMIT:      cfg_r.route_limit      <= cfg_data;
        CFG_ID_LIMIT:         cfg_r.id_limit         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_word_r <= in_word;
    if (s1_valid_r && adv) out_word_r <= step_result;
  end

endmodule

`default_nettype wire

>>> rtl/core/rsrp_checker.sv
// port-level assertions for the route state record parser, with its bind
`default_nettype none

module rsrp_checker
  import rsrp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.done_res |-> out_word.status == ST_OK)
    else $error("status set before last byte");

  a_no_field_on_ids: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.field_done |->
      out_word.byte_role != ROLE_INSTR && out_word.byte_role != ROLE_PARAM &&
      out_word.byte_role != ROLE_IGNORED)
    else $error("field completed on id or ignored byte");

  a_value_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.field_done |-> out_word.field_value == 32'd0)
    else $error("field value without completed field");

  a_header_route_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.byte_role == ROLE_MAGIC || out_word.byte_role == ROLE_VERSION ||
                  out_word.byte_role == ROLE_COUNT) |-> out_word.route_number == 16'd0)
    else $error("header byte carries a route number");

endmodule

bind route_state_record_parser rsrp_checker u_rsrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
